// File: hdl/ccps_pkg.sv
// ----------------------------------------------------------------------------
// ccps_pkg
// Shared types and constants of the character-class pattern search core.
// ----------------------------------------------------------------------------
package ccps_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_SEGMENTS    = 8;
	localparam int DEF_MAX_REPEAT      = 8;
	localparam int DEF_MAX_PATTERN_LEN = 64;

	// hard limits set by the fixed field widths
	localparam int SEG_LIMIT = 8;   // one member_mask bit per segment
	localparam int SEG_W     = 3;   // segment index
	localparam int MEMBER_W  = 8;
	localparam int BYTE_W    = 8;
	localparam int MEM_DEPTH = 256;
	localparam int POS_W     = 16;
	localparam int LEN_W     = 7;   // holds 8 x 15, the largest repeat sum
	localparam int NIB_W     = 4;
	localparam int CNT_W     = 4;   // segment_count register
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNTS = 1'b1;

	// register reset values
	localparam logic [CNT_W-1:0] RST_SEGMENT_COUNT = 4'd1;
	localparam logic [CFG_W-1:0] RST_REPEAT_COUNTS = 32'h1111_1111;

	// action codes carried in tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEXT = 1'b1;

	// control of the request held in the lookup stage
	typedef struct packed {
		logic valid;
		logic text;
		logic last;
	} item_ctl_t;

endpackage

// File: hdl/char_class_pattern_search_core.sv
// ----------------------------------------------------------------------------
// char_class_pattern_search_core
// Leftmost character-class pattern search over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Program segment_count and repeat_counts over the cfg port while idle.
//   Each s_ request carries an action in s_tuser: a load writes member_mask
//   (s_tdata[15:8]) as the class bits of byte value s_tdata[7:0]; a text
//   request feeds s_tdata[7:0] as the next text byte, and s_tlast marks the
//   final byte of a text. After that final byte one result request appears
//   on m_: found, match_start, match_length and overflow.
// Throughput: one request per cycle while no stall holds the lookup stage,
//   set by the membership memory's single read port and the shift-and update.
// Result path: the final byte passes the memory read register, then the
//   vector update into the result register, before the result is presented.
// Reset: membership entries read as zero until loaded (one valid bit per
//   byte value), stream state clears, registers return to one segment with
//   every repeat count at 1. No clearing pass is needed.
// Stall: the result register holds while m_tready is low; further requests
//   are still taken until another final byte reaches the update stage.
// ----------------------------------------------------------------------------
module char_class_pattern_search_core import ccps_pkg::*; #(
	parameter int MAX_SEGMENTS    = DEF_MAX_SEGMENTS,
	parameter int MAX_REPEAT      = DEF_MAX_REPEAT,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // byte_value[7:0], member_mask[15:8]
	input  logic                  s_tuser,   // action[0]
	input  logic                  s_tlast,   // last_byte
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // found[0], match_start[16:1],
	                                         // match_length[23:17], overflow[24]
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	logic [SEG_W-1:0]           pos_seg [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0] pos_valid;
	logic [MAX_PATTERN_LEN-1:0] last_mask;
	logic [LEN_W-1:0]           pat_len;

	item_ctl_t           ctl_s1;
	logic [MEMBER_W-1:0] member_s1;
	logic                stall;
	logic                accept;

	logic             found;
	logic [POS_W-1:0] match_start;
	logic [LEN_W-1:0] match_length;
	logic             overflow;

	// take a request whenever the update stage is not held
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;

	// registers and expanded position map
	ccps_pattern_map #(
		.MAX_SEGMENTS    (MAX_SEGMENTS),
		.MAX_REPEAT      (MAX_REPEAT),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pos_seg   (pos_seg),
		.pos_valid (pos_valid),
		.last_mask (last_mask),
		.pat_len   (pat_len)
	);

	// membership memory: write on load, registered read on every request
	ccps_class_mem u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (s_tuser),
		.byte_value  (s_tdata[BYTE_W-1:0]),
		.member_mask (s_tdata[BYTE_W +: MEMBER_W]),
		.last_byte   (s_tlast),
		.stall       (stall),
		.ctl_s1      (ctl_s1),
		.member_s1   (member_s1)
	);

	// advance the active vector and produce the result
	ccps_shift_match #(
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.member_s1    (member_s1),
		.pos_seg      (pos_seg),
		.pos_valid    (pos_valid),
		.last_mask    (last_mask),
		.pat_len      (pat_len),
		.out_ready    (m_tready),
		.stall        (stall),
		.out_valid    (m_tvalid),
		.found        (found),
		.match_start  (match_start),
		.match_length (match_length),
		.overflow     (overflow)
	);

	// pack the result, zero-fill to whole bytes
	assign m_tdata = {
		{(OUT_DATA_W - 1 - POS_W - LEN_W - 1){1'b0}},
		overflow, match_length, match_start, found
	};

endmodule

// File: hdl/ccps_pattern_map.sv
// ----------------------------------------------------------------------------
// ccps_pattern_map
// Configuration registers and the expanded position map derived from them.
// ----------------------------------------------------------------------------
module ccps_pattern_map import ccps_pkg::*; #(
	parameter int MAX_SEGMENTS    = DEF_MAX_SEGMENTS,
	parameter int MAX_REPEAT      = DEF_MAX_REPEAT,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]           cfg_wdata,
	output logic [SEG_W-1:0]           pos_seg [MAX_PATTERN_LEN],
	output logic [MAX_PATTERN_LEN-1:0] pos_valid,
	output logic [MAX_PATTERN_LEN-1:0] last_mask,
	output logic [LEN_W-1:0]           pat_len
);

	localparam int SEG_CAP = (MAX_SEGMENTS < SEG_LIMIT) ? MAX_SEGMENTS : SEG_LIMIT;

	logic [CNT_W-1:0] segment_count_q;
	logic [CFG_W-1:0] repeat_counts_q;

	logic [CNT_W-1:0] used;
	logic [NIB_W-1:0] rep   [SEG_LIMIT];
	logic [LEN_W-1:0] start [SEG_LIMIT+1];
	logic [LEN_W-1:0] len;
	logic [SEG_W-1:0]           seg_d [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0] valid_d;
	logic [MAX_PATTERN_LEN-1:0] last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= RST_SEGMENT_COUNT;
			repeat_counts_q <= RST_REPEAT_COUNTS;
		end else if (cfg_we) begin
			if (cfg_idx == REG_SEGMENT_COUNT)
				segment_count_q <= cfg_wdata[CNT_W-1:0];
			else if (cfg_idx == REG_REPEAT_COUNTS)
				repeat_counts_q <= cfg_wdata;
		end
	end

	always_comb begin
		used = segment_count_q;
		if (used == '0)
			used = CNT_W'(1);
		if (used > CNT_W'(SEG_CAP))
			used = CNT_W'(SEG_CAP);
		// clamp each repeat; segments beyond the count take no positions
		for (int s = 0; s < SEG_LIMIT; s++) begin
			rep[s] = repeat_counts_q[s*NIB_W +: NIB_W];
			if (rep[s] == '0)
				rep[s] = NIB_W'(1);
			if (rep[s] > NIB_W'(MAX_REPEAT))
				rep[s] = NIB_W'(MAX_REPEAT);
			if (CNT_W'(s) >= used)
				rep[s] = '0;
		end
		start[0] = '0;
		for (int s = 0; s < SEG_LIMIT; s++)
			start[s+1] = start[s] + LEN_W'(rep[s]);
		len = (start[SEG_LIMIT] > LEN_W'(MAX_PATTERN_LEN)) ?
			LEN_W'(MAX_PATTERN_LEN) : start[SEG_LIMIT];
		for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
			seg_d[p]   = '0;
			valid_d[p] = (LEN_W'(p) < len);
			last_d[p]  = (LEN_W'(p) == len - LEN_W'(1));
			for (int s = 0; s < SEG_LIMIT; s++) begin
				if (LEN_W'(p) >= start[s] && LEN_W'(p) < start[s+1])
					seg_d[p] = SEG_W'(s);
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_seg   <= seg_d;
		pos_valid <= valid_d;
		last_mask <= last_d;
		pat_len   <= len;
	end

endmodule

// File: hdl/ccps_class_mem.sv
// ----------------------------------------------------------------------------
// ccps_class_mem
// Class membership memory with per-entry valid bits and the lookup stage.
// ----------------------------------------------------------------------------
module ccps_class_mem import ccps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	input  logic [BYTE_W-1:0]   byte_value,
	input  logic [MEMBER_W-1:0] member_mask,
	input  logic                last_byte,
	input  logic                stall,
	output item_ctl_t           ctl_s1,
	output logic [MEMBER_W-1:0] member_s1
);

	logic [MEMBER_W-1:0]  mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	logic [MEMBER_W-1:0]  rdata_s1;
	logic                 rvalid_s1;

	// write on the accepting edge of a load; a later read sees it
	always_ff @(posedge clk) begin
		if (accept && action == ACT_LOAD)
			mem_q[byte_value] <= member_mask;
	end

	always_ff @(posedge clk) begin
		if (accept)
			rdata_s1 <= mem_q[byte_value];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			ctl_s1    <= '0;
		end else begin
			if (accept && action == ACT_LOAD)
				valid_q[byte_value] <= 1'b1;
			if (accept)
				rvalid_s1 <= valid_q[byte_value];
			if (!stall) begin
				ctl_s1.valid <= accept;
				ctl_s1.text  <= (action == ACT_TEXT);
				ctl_s1.last  <= last_byte;
			end
		end
	end

	assign member_s1 = rvalid_s1 ? rdata_s1 : '0;

endmodule

// File: hdl/ccps_shift_match.sv
// ----------------------------------------------------------------------------
// ccps_shift_match
// Shift-and active vector, stream counters and the result register.
// ----------------------------------------------------------------------------
module ccps_shift_match import ccps_pkg::*; #(
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  item_ctl_t                  ctl_s1,
	input  logic [MEMBER_W-1:0]        member_s1,
	input  logic [SEG_W-1:0]           pos_seg [MAX_PATTERN_LEN],
	input  logic [MAX_PATTERN_LEN-1:0] pos_valid,
	input  logic [MAX_PATTERN_LEN-1:0] last_mask,
	input  logic [LEN_W-1:0]           pat_len,
	input  logic                       out_ready,
	output logic                       stall,
	output logic                       out_valid,
	output logic                       found,
	output logic [POS_W-1:0]           match_start,
	output logic [LEN_W-1:0]           match_length,
	output logic                       overflow
);

	localparam int L = MAX_PATTERN_LEN;

	logic [L-1:0]     active_q;
	logic [POS_W-1:0] pos_q;
	logic             seen_q;
	logic [POS_W-1:0] first_q;
	logic             ovf_q;
	logic             out_valid_q;

	logic [L-1:0]     mask;
	logic [L:0]       shifted;
	logic [L-1:0]     active_nx;
	logic             hit;
	logic             seen_nx;
	logic             ovf_nx;
	logic [POS_W-1:0] start_here;
	logic [POS_W-1:0] start_nx;
	logic             fire;

	// hold the lookup stage while its final text byte waits behind a finished result
	assign stall = ctl_s1.valid && ctl_s1.text && ctl_s1.last && out_valid_q && !out_ready;
	assign fire  = ctl_s1.valid && ctl_s1.text && !stall;

	always_comb begin
		for (int p = 0; p < L; p++)
			mask[p] = pos_valid[p] && member_s1[pos_seg[p]];
		shifted    = {active_q, 1'b1};
		active_nx  = shifted[L-1:0] & mask;
		hit        = |(active_nx & last_mask);
		seen_nx    = seen_q || hit;
		ovf_nx     = ovf_q || (pos_q == '1);
		start_here = pos_q - POS_W'(pat_len) + POS_W'(1);
		start_nx   = seen_q ? first_q : start_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			pos_q       <= '0;
			seen_q      <= 1'b0;
			first_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (ctl_s1.last) begin
					active_q <= '0;
					pos_q    <= '0;
					seen_q   <= 1'b0;
					first_q  <= '0;
					ovf_q    <= 1'b0;
				end else begin
					active_q <= active_nx;
					if (pos_q != '1)
						pos_q <= pos_q + POS_W'(1);
					seen_q  <= seen_nx;
					first_q <= seen_nx ? start_nx : '0;
					ovf_q   <= ovf_nx;
				end
			end
			if (fire && ctl_s1.last)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl_s1.last) begin
			found        <= seen_nx;
			match_start  <= seen_nx ? start_nx : '0;
			match_length <= seen_nx ? pat_len : '0;
			overflow     <= ovf_nx;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/ccps_checker.sv
// ----------------------------------------------------------------------------
// ccps_checker
// Port-level checks of the pattern search core, bound to the top level.
// ----------------------------------------------------------------------------
module ccps_checker import ccps_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// no match means zero start and length
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[23:1] == '0)
		else $error("miss carries nonzero start or length");

	// a fresh result follows an accepted final text byte
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |->
			$past(s_tvalid && s_tready && s_tlast && s_tuser == ACT_TEXT, 2))
		else $error("result without a final text byte");

endmodule

bind char_class_pattern_search_core ccps_checker u_ccps_checker (.*);
